// File: rtl/tps_pkg.sv
// Shared types and constants of the triangle plane slice unit.
package tps_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned QueueDepth = 4;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t vertex0_x;
    coord_t vertex0_y;
    coord_t vertex0_z;
    coord_t vertex1_x;
    coord_t vertex1_y;
    coord_t vertex1_z;
    coord_t vertex2_x;
    coord_t vertex2_y;
    coord_t vertex2_z;
    coord_t plane_z;
  } tps_in_t;

  typedef struct packed {
    logic   segment_valid;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } tps_out_t;

  // one edge to interpolate on: from (a, za) to (b, zb)
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t za;
    coord_t zb;
  } tps_edge_t;

  typedef struct packed {
    logic      none;
    coord_t    p;
    tps_edge_t edge_s;
    tps_edge_t edge_e;
  } tps_job_t;

endpackage

// File: rtl/tps_front.sv
// Front part: input register, stable sort by z and edge selection.
module tps_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tps_pkg::tps_in_t in_data_i,
  input  logic             full_i,
  output logic             push_o,
  output tps_pkg::tps_job_t job_o
);
  import tps_pkg::*;

  logic    valid_q;
  tps_in_t item_q;
  logic    adv;

  coord_t vx [3];
  coord_t vy [3];
  coord_t vz [3];
  coord_t sx [3];
  coord_t sy [3];
  coord_t sz [3];
  logic [1:0] rank [3];
  logic g01, g12, g02;
  logic on0, on1, on2, below, above;
  coord_t p;

  assign adv        = !valid_q || !full_i;
  assign in_stall_o = valid_q && full_i;
  assign push_o     = valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  always_comb begin
    vx[0] = item_q.vertex0_x; vy[0] = item_q.vertex0_y; vz[0] = item_q.vertex0_z;
    vx[1] = item_q.vertex1_x; vy[1] = item_q.vertex1_y; vz[1] = item_q.vertex1_z;
    vx[2] = item_q.vertex2_x; vy[2] = item_q.vertex2_y; vz[2] = item_q.vertex2_z;
    p     = item_q.plane_z;

    g01 = vz[0] > vz[1];
    g12 = vz[1] > vz[2];
    g02 = vz[0] > vz[2];
    // rank: how many vertices come before this one in a stable order
    rank[0] = {1'b0, g01} + {1'b0, g02};
    rank[1] = {1'b0, !g01} + {1'b0, g12};
    rank[2] = {1'b0, !g02} + {1'b0, !g12};

    for (int r = 0; r < 3; r++) begin
      sx[r] = vx[0];
      sy[r] = vy[0];
      sz[r] = vz[0];
      for (int i = 0; i < 3; i++) begin
        if (rank[i] == 2'(r)) begin
          sx[r] = vx[i];
          sy[r] = vy[i];
          sz[r] = vz[i];
        end
      end
    end

    on0   = sz[0] == p;
    on1   = sz[1] == p;
    on2   = sz[2] == p;
    below = p < sz[0];
    above = p > sz[2];

    job_o.none = (on0 && on1 && on2) || below || above;
    job_o.p    = p;

    if ((on0 && on1) || (on0 && on2) || (on1 && on2)) begin
      // edge in the plane: zero-height edges give their start value back
      job_o.edge_s = '{ax: on0 ? sx[0] : sx[1], ay: on0 ? sy[0] : sy[1],
                       bx: on0 ? sx[0] : sx[1], by: on0 ? sy[0] : sy[1],
                       za: p, zb: p};
      job_o.edge_e = '{ax: (on0 && on1) ? sx[1] : sx[2],
                       ay: (on0 && on1) ? sy[1] : sy[2],
                       bx: (on0 && on1) ? sx[1] : sx[2],
                       by: (on0 && on1) ? sy[1] : sy[2],
                       za: p, zb: p};
    end else if (sz[1] <= p) begin
      job_o.edge_s = '{ax: sx[0], ay: sy[0], bx: sx[2], by: sy[2], za: sz[0], zb: sz[2]};
      job_o.edge_e = '{ax: sx[1], ay: sy[1], bx: sx[2], by: sy[2], za: sz[1], zb: sz[2]};
    end else begin
      job_o.edge_s = '{ax: sx[0], ay: sy[0], bx: sx[1], by: sy[1], za: sz[0], zb: sz[1]};
      job_o.edge_e = '{ax: sx[0], ay: sy[0], bx: sx[2], by: sy[2], za: sz[0], zb: sz[2]};
    end
  end

endmodule

// File: rtl/tps_queue.sv
// Short flop queue between the front and back parts.
module tps_queue #(
  parameter int unsigned DEPTH = tps_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tps_pkg::tps_job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              avail_o,
  output tps_pkg::tps_job_t head_o
);
  import tps_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tps_job_t            mem_q [DEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign avail_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/tps_lerp.sv
// One interpolation lane: differences, wide product, pipelined restoring divide.
module tps_lerp (
  input  logic            clk_i,
  input  logic            en_i,
  input  tps_pkg::coord_t ca_i,
  input  tps_pkg::coord_t cb_i,
  input  tps_pkg::coord_t za_i,
  input  tps_pkg::coord_t zb_i,
  input  tps_pkg::coord_t p_i,
  output tps_pkg::coord_t res_o
);
  import tps_pkg::*;

  localparam int unsigned W = CoordW;

  logic signed [W:0] dc, tw, dw;
  logic [W:0]        magw;

  logic [W-1:0] mag0_q, t0_q, den0_q;
  logic         neg0_q, dz0_q;
  coord_t       ca0_q;

  logic [2*W-1:0] prod1_q;
  logic [W-1:0]   den1_q;
  logic           neg1_q, dz1_q;
  coord_t         ca1_q;

  logic [W-1:0] rem_q [W];
  logic [W-1:0] lo_q  [W];
  logic [W-1:0] quo_q [W];
  logic [W-1:0] den_q [W];
  logic         neg_q [W];
  logic         dz_q  [W];
  coord_t       ca_q  [W];

  logic [W-1:0] rem_in [W];
  logic [W-1:0] lo_in  [W];
  logic [W-1:0] quo_in [W];
  logic [W-1:0] den_in [W];
  logic         neg_in [W];
  logic         dz_in  [W];
  coord_t       ca_in  [W];

  assign dc   = $signed({cb_i[W-1], cb_i}) - $signed({ca_i[W-1], ca_i});
  assign tw   = $signed({p_i[W-1], p_i}) - $signed({za_i[W-1], za_i});
  assign dw   = $signed({zb_i[W-1], zb_i}) - $signed({za_i[W-1], za_i});
  assign magw = dc[W] ? -dc : dc;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag0_q  <= magw[W-1:0];
      t0_q    <= tw[W-1:0];
      den0_q  <= dw[W-1:0];
      neg0_q  <= dc[W];
      dz0_q   <= (dw == '0);
      ca0_q   <= ca_i;
      prod1_q <= {{W{1'b0}}, mag0_q} * {{W{1'b0}}, t0_q};
      den1_q  <= den0_q;
      neg1_q  <= neg0_q;
      dz1_q   <= dz0_q;
      ca1_q   <= ca0_q;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0] sh;
    logic       ge;
    logic [W:0] diff;

    if (k == 0) begin : g_first
      assign rem_in[k] = prod1_q[2*W-1:W];
      assign lo_in[k]  = prod1_q[W-1:0];
      assign quo_in[k] = '0;
      assign den_in[k] = den1_q;
      assign neg_in[k] = neg1_q;
      assign dz_in[k]  = dz1_q;
      assign ca_in[k]  = ca1_q;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign lo_in[k]  = lo_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign den_in[k] = den_q[k-1];
      assign neg_in[k] = neg_q[k-1];
      assign dz_in[k]  = dz_q[k-1];
      assign ca_in[k]  = ca_q[k-1];
    end

    assign sh   = {rem_in[k], lo_in[k][W-1]};
    assign ge   = sh >= {1'b0, den_in[k]};
    assign diff = sh - {1'b0, den_in[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[W-1:0] : sh[W-1:0];
        lo_q[k]  <= {lo_in[k][W-2:0], 1'b0};
        quo_q[k] <= {quo_in[k][W-2:0], ge};
        den_q[k] <= den_in[k];
        neg_q[k] <= neg_in[k];
        dz_q[k]  <= dz_in[k];
        ca_q[k]  <= ca_in[k];
      end
    end
  end

  always_comb begin
    if (dz_q[W-1]) begin
      res_o = ca_q[W-1];
    end else if (neg_q[W-1]) begin
      res_o = ca_q[W-1] - $signed(quo_q[W-1]);
    end else begin
      res_o = ca_q[W-1] + $signed(quo_q[W-1]);
    end
  end

endmodule

// File: rtl/tps_back.sv
// Back part: four interpolation lanes and the output register.
module tps_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  tps_pkg::tps_job_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tps_pkg::tps_out_t out_data_o
);
  import tps_pkg::*;

  localparam int unsigned Lat = CoordW + 2;

  logic           en;
  logic [Lat-1:0] vld_q, none_q;
  logic           out_valid_q;
  tps_out_t       out_q;
  coord_t         sx, sy, ex, ey;
  logic           ok;

  assign en          = !out_valid_q || !out_stall_i;
  assign pop_o       = en && avail_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  tps_lerp u_sx (.clk_i, .en_i(en), .ca_i(head_i.edge_s.ax), .cb_i(head_i.edge_s.bx),
                 .za_i(head_i.edge_s.za), .zb_i(head_i.edge_s.zb), .p_i(head_i.p),
                 .res_o(sx));
  tps_lerp u_sy (.clk_i, .en_i(en), .ca_i(head_i.edge_s.ay), .cb_i(head_i.edge_s.by),
                 .za_i(head_i.edge_s.za), .zb_i(head_i.edge_s.zb), .p_i(head_i.p),
                 .res_o(sy));
  tps_lerp u_ex (.clk_i, .en_i(en), .ca_i(head_i.edge_e.ax), .cb_i(head_i.edge_e.bx),
                 .za_i(head_i.edge_e.za), .zb_i(head_i.edge_e.zb), .p_i(head_i.p),
                 .res_o(ex));
  tps_lerp u_ey (.clk_i, .en_i(en), .ca_i(head_i.edge_e.ay), .cb_i(head_i.edge_e.by),
                 .za_i(head_i.edge_e.za), .zb_i(head_i.edge_e.zb), .p_i(head_i.p),
                 .res_o(ey));

  assign ok = !none_q[Lat-1] && !(sx == ex && sy == ey);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Lat-2:0], avail_i};
      out_valid_q <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      none_q <= {none_q[Lat-2:0], head_i.none};
      out_q  <= '{segment_valid: ok,
                  start_x: ok ? sx : '0, start_y: ok ? sy : '0,
                  end_x:   ok ? ex : '0, end_y:   ok ? ey : '0};
    end
  end

endmodule

// File: rtl/triangle_plane_slice_unit.sv
// Top level of the triangle plane slice unit.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_stall_o  | in_data_i  (tps_in_t)
//   out     | output    | out_valid_o/out_stall_i| out_data_o (tps_out_t)
//
// A triangle is accepted and a result delivered per cycle while the output is
// not stalled; data pass the input register, queue, difference and product
// registers, the one-bit-a-stage divider in each lane and output register.
// A stall on the output freezes the back pipeline; the queue then fills and
// the input stalls only once it is full. Reset clears all valid state.
module triangle_plane_slice_unit #(
  parameter int unsigned QUEUE_DEPTH = tps_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tps_pkg::tps_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tps_pkg::tps_out_t out_data_o
);
  import tps_pkg::*;

  tps_job_t job, head;
  logic     push, full, pop, avail;

  tps_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .full_i(full), .push_o(push), .job_o(job)
  );

  tps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(job), .full_o(full),
    .pop_i(pop), .avail_o(avail), .head_o(head)
  );

  tps_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  a_zero_when_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.segment_valid |->
      out_data_o.start_x == '0 && out_data_o.start_y == '0 &&
      out_data_o.end_x == '0 && out_data_o.end_y == '0)
    else $error("dropped segment carries nonzero coordinates");

  a_nonzero_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.segment_valid |->
      !(out_data_o.start_x == out_data_o.end_x &&
        out_data_o.start_y == out_data_o.end_y))
    else $error("segment of zero length flagged valid");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !pop |-> !push)
    else $error("queue overrun");

endmodule
